[hw/rtl/assert_macros.svh]
// Assertion helpers used by camera_ray_direction_generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[hw/rtl/crdg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package crdg_pkg;
	localparam logic [30:0] TWO_PI_Q = 31'd1686629713;
	localparam logic [30:0] PI_Q = 31'd843314857;
	localparam logic [30:0] HALF_PI_Q = 31'd421657428;
	localparam int XY_W = 33;
	localparam int PW = 2 * XY_W;
	localparam logic signed [XY_W-1:0] GAIN_Q30 = 33'sd652032874;
	localparam logic [31:0] ATAN_TAB [30] = '{
		32'd210828714, 32'd124459457, 32'd65760959, 32'd33381290, 32'd16755422,
		32'd8385879, 32'd4193963, 32'd2097109, 32'd1048571, 32'd524287,
		32'd262144, 32'd131072, 32'd65536, 32'd32768, 32'd16384, 32'd8192,
		32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256, 32'd128, 32'd64,
		32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
	};

	typedef enum logic [2:0] {
		REG_FOV_H = 3'd0,
		REG_FOV_V = 3'd1,
		REG_STEP_H = 3'd2,
		REG_STEP_V = 3'd3,
		REG_WIDTH = 3'd4,
		REG_HEIGHT = 3'd5
	} crdg_reg_t;

	typedef struct packed {
		logic vld;
		logic oor;
	} crdg_side_t;

	function automatic logic signed [17:0] sat18(input logic signed [23:0] v);
		logic signed [17:0] r;
		if (v > 24'sd65536) begin
			r = 18'sd65536;
		end else if (v < -24'sd65536) begin
			r = -18'sd65536;
		end else begin
			r = v[17:0];
		end
		return r;
	endfunction
endpackage
`default_nettype wire

[hw/rtl/crdg_mod_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
module crdg_mod_cell import crdg_pkg::*; #(
	parameter int MAG_W = 43,
	parameter int K = 0
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [MAG_W-1:0] prev_mag,
	input  wire logic             prev_sign,
	output logic      [MAG_W-1:0] next_mag,
	output logic                  next_sign
);
	localparam logic [MAG_W-1:0] SUB = MAG_W'(TWO_PI_Q) << K;

	logic [MAG_W-1:0] mag_q;
	logic             sign_q;

	always_ff @(posedge clk) begin
		if (en) begin
			mag_q <= (prev_mag >= SUB) ? prev_mag - SUB : prev_mag;
			sign_q <= prev_sign;
		end
	end

	assign next_mag = mag_q;
	assign next_sign = sign_q;
endmodule
`default_nettype wire

[hw/rtl/crdg_fold.sv]
`timescale 1ns / 1ps
`default_nettype none
module crdg_fold import crdg_pkg::*; (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic        [30:0] rem,
	input  wire logic               sign,
	output logic signed      [31:0] angle,
	output logic                    neg
);
	logic        [30:0] r_s1;
	logic signed [31:0] r_s2;
	logic signed [31:0] r_s3;
	logic               neg_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1 <= (sign && rem != '0) ? TWO_PI_Q - rem : rem;
			r_s2 <= (r_s1 >= PI_Q) ? $signed({1'b0, r_s1}) - $signed({1'b0, TWO_PI_Q})
				: $signed({1'b0, r_s1});
			if (r_s2 > $signed({1'b0, HALF_PI_Q})) begin
				r_s3 <= r_s2 - $signed({1'b0, PI_Q});
				neg_s3 <= 1'b1;
			end else if (r_s2 < -$signed({1'b0, HALF_PI_Q})) begin
				r_s3 <= r_s2 + $signed({1'b0, PI_Q});
				neg_s3 <= 1'b1;
			end else begin
				r_s3 <= r_s2;
				neg_s3 <= 1'b0;
			end
		end
	end

	assign angle = r_s3;
	assign neg = neg_s3;
endmodule
`default_nettype wire

[hw/rtl/crdg_cordic_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
module crdg_cordic_cell import crdg_pkg::*; #(
	parameter int I = 0
) (
	input  wire logic                   clk,
	input  wire logic                   en,
	input  wire logic signed [XY_W-1:0] prev_x,
	input  wire logic signed [XY_W-1:0] prev_y,
	input  wire logic signed [31:0]     prev_z,
	input  wire logic                   prev_neg,
	output logic signed      [XY_W-1:0] next_x,
	output logic signed      [XY_W-1:0] next_y,
	output logic signed      [31:0]     next_z,
	output logic                        next_neg
);
	localparam logic signed [31:0] ANG = $signed(ATAN_TAB[I]);

	logic signed [XY_W-1:0] x_q;
	logic signed [XY_W-1:0] y_q;
	logic signed [31:0]     z_q;
	logic                   neg_q;
	logic signed [XY_W-1:0] dx;
	logic signed [XY_W-1:0] dy;

	assign dx = prev_y >>> I;
	assign dy = prev_x >>> I;

	always_ff @(posedge clk) begin
		if (en) begin
			if (prev_z >= 0) begin
				x_q <= prev_x - dx;
				y_q <= prev_y + dy;
				z_q <= prev_z - ANG;
			end else begin
				x_q <= prev_x + dx;
				y_q <= prev_y - dy;
				z_q <= prev_z + ANG;
			end
			neg_q <= prev_neg;
		end
	end

	assign next_x = x_q;
	assign next_y = y_q;
	assign next_z = z_q;
	assign next_neg = neg_q;
endmodule
`default_nettype wire

[hw/rtl/camera_ray_direction_generator.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Gives the unit view-ray direction for one pixel, one word per clock cycle when the output
// side keeps taking words. A word passes from input to output through multiply and angle
// setup (registers s1 to s4), COORD_BITS + 1 cells of modulo-2pi reduction, folding (r_s1 to
// r_s3), one CORDIC cell per stage, product and rounding (s5 to s7), and the output
// register. A two-entry output buffer keeps in_ready a register.
module camera_ray_direction_generator import crdg_pkg::*; #(
	parameter int CORDIC_STAGES = 18,
	parameter int COORD_BITS = 12
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [2:0]              cfg_index,
	input  wire logic [30:0]             cfg_data,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [COORD_BITS-1:0]   column,
	input  wire logic [COORD_BITS-1:0]   pixel_row,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic signed [17:0]           dir_x,
	output logic signed [17:0]           dir_y,
	output logic signed [17:0]           dir_z,
	output logic                         out_of_range
);
	localparam int MAG_W = COORD_BITS + 31;
	localparam int SW = MAG_W + 1;
	localparam int NRED = COORD_BITS + 1;
	localparam int CS = CORDIC_STAGES;
	localparam int LAT = 4 + NRED + 3 + CS + 3;
	localparam int CMP_W = ((COORD_BITS > 13) ? COORD_BITS : 13) + 1;

	logic [30:0] fov_h_q, fov_v_q, step_h_q, step_v_q;
	logic [12:0] width_q, height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fov_h_q <= 31'd281104971;
			fov_v_q <= 31'd210828714;
			step_h_q <= 31'd281105;
			step_v_q <= 31'd263536;
			width_q <= 13'd1000;
			height_q <= 13'd800;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FOV_H: fov_h_q <= cfg_data;
				REG_FOV_V: fov_v_q <= cfg_data;
				REG_STEP_H: step_h_q <= cfg_data;
				REG_STEP_V: step_v_q <= cfg_data;
				REG_WIDTH: width_q <= cfg_data[12:0];
				REG_HEIGHT: height_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	logic en;
	logic skid_v_q;
	logic out_v_q;
	crdg_side_t side_q [LAT];

	assign in_ready = !skid_v_q;
	assign en = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) begin
				side_q[i] <= '0;
			end
		end else if (en) begin
			side_q[0].vld <= in_valid;
			side_q[0].oor <= (CMP_W'(column) >= CMP_W'(width_q))
				|| (CMP_W'(pixel_row) >= CMP_W'(height_q));
			for (int i = 1; i < LAT; i++) begin
				side_q[i] <= side_q[i-1];
			end
		end
	end

	logic [COORD_BITS-1:0] col_s1, row_s1;
	logic [MAG_W-1:0]      prod_h_s2, prod_v_s2;
	logic signed [SW-1:0]  yaw_s3, pitch_s3;
	logic [MAG_W-1:0]      ymag_s4, pmag_s4;
	logic                  ysign_s4, psign_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			col_s1 <= column;
			row_s1 <= pixel_row;
			prod_h_s2 <= MAG_W'(col_s1) * MAG_W'(step_h_q);
			prod_v_s2 <= MAG_W'(row_s1) * MAG_W'(step_v_q);
			yaw_s3 <= $signed({1'b0, prod_h_s2}) - $signed(SW'(fov_h_q[30:1]));
			pitch_s3 <= $signed(SW'(fov_v_q[30:1])) - $signed({1'b0, prod_v_s2});
			ysign_s4 <= yaw_s3[SW-1];
			psign_s4 <= pitch_s3[SW-1];
			ymag_s4 <= yaw_s3[SW-1] ? MAG_W'(-yaw_s3) : MAG_W'(yaw_s3);
			pmag_s4 <= pitch_s3[SW-1] ? MAG_W'(-pitch_s3) : MAG_W'(pitch_s3);
		end
	end

	logic [MAG_W-1:0] ymag [NRED];
	logic [MAG_W-1:0] pmag [NRED];
	logic             ysign [NRED];
	logic             psign [NRED];

	for (genvar j = 0; j < NRED; j++) begin : g_red
		if (j == 0) begin : g_first
			crdg_mod_cell #(.MAG_W(MAG_W), .K(NRED - 1 - j)) u_yaw (
				.clk(clk), .en(en), .prev_mag(ymag_s4), .prev_sign(ysign_s4),
				.next_mag(ymag[j]), .next_sign(ysign[j]));
			crdg_mod_cell #(.MAG_W(MAG_W), .K(NRED - 1 - j)) u_pitch (
				.clk(clk), .en(en), .prev_mag(pmag_s4), .prev_sign(psign_s4),
				.next_mag(pmag[j]), .next_sign(psign[j]));
		end else begin : g_next
			crdg_mod_cell #(.MAG_W(MAG_W), .K(NRED - 1 - j)) u_yaw (
				.clk(clk), .en(en), .prev_mag(ymag[j-1]), .prev_sign(ysign[j-1]),
				.next_mag(ymag[j]), .next_sign(ysign[j]));
			crdg_mod_cell #(.MAG_W(MAG_W), .K(NRED - 1 - j)) u_pitch (
				.clk(clk), .en(en), .prev_mag(pmag[j-1]), .prev_sign(psign[j-1]),
				.next_mag(pmag[j]), .next_sign(psign[j]));
		end
	end

	logic signed [31:0] yz0, pz0;
	logic               yneg0, pneg0;

	crdg_fold u_fold_yaw (
		.clk(clk), .en(en), .rem(ymag[NRED-1][30:0]), .sign(ysign[NRED-1]),
		.angle(yz0), .neg(yneg0));
	crdg_fold u_fold_pitch (
		.clk(clk), .en(en), .rem(pmag[NRED-1][30:0]), .sign(psign[NRED-1]),
		.angle(pz0), .neg(pneg0));

	logic signed [XY_W-1:0] yx [CS];
	logic signed [XY_W-1:0] yy [CS];
	logic signed [31:0]     yz [CS];
	logic                   yn [CS];
	logic signed [XY_W-1:0] px [CS];
	logic signed [XY_W-1:0] py [CS];
	logic signed [31:0]     pz [CS];
	logic                   pn [CS];

	for (genvar j = 0; j < CS; j++) begin : g_cordic
		if (j == 0) begin : g_first
			crdg_cordic_cell #(.I(j)) u_yaw (
				.clk(clk), .en(en), .prev_x(GAIN_Q30), .prev_y('0), .prev_z(yz0),
				.prev_neg(yneg0), .next_x(yx[j]), .next_y(yy[j]), .next_z(yz[j]),
				.next_neg(yn[j]));
			crdg_cordic_cell #(.I(j)) u_pitch (
				.clk(clk), .en(en), .prev_x(GAIN_Q30), .prev_y('0), .prev_z(pz0),
				.prev_neg(pneg0), .next_x(px[j]), .next_y(py[j]), .next_z(pz[j]),
				.next_neg(pn[j]));
		end else begin : g_next
			crdg_cordic_cell #(.I(j)) u_yaw (
				.clk(clk), .en(en), .prev_x(yx[j-1]), .prev_y(yy[j-1]),
				.prev_z(yz[j-1]), .prev_neg(yn[j-1]), .next_x(yx[j]), .next_y(yy[j]),
				.next_z(yz[j]), .next_neg(yn[j]));
			crdg_cordic_cell #(.I(j)) u_pitch (
				.clk(clk), .en(en), .prev_x(px[j-1]), .prev_y(py[j-1]),
				.prev_z(pz[j-1]), .prev_neg(pn[j-1]), .next_x(px[j]), .next_y(py[j]),
				.next_z(pz[j]), .next_neg(pn[j]));
		end
	end

	logic signed [XY_W-1:0] cy_s5, sy_s5, cp_s5, sp_s5;
	logic signed [PW-1:0]   mx_s6, my_s6;
	logic signed [XY_W-1:0] sp_s6;
	logic signed [17:0]     fx_s7, fy_s7, fz_s7;
	logic signed [PW-1:0]   rx, ry;
	logic signed [XY_W-1:0] rz;

	localparam logic signed [PW-1:0] HALF_P = PW'(64'sd1 <<< 43);
	localparam logic signed [XY_W-1:0] HALF_Z = XY_W'(33'sd1 <<< 13);

	assign rx = mx_s6 + HALF_P;
	assign ry = my_s6 + HALF_P;
	assign rz = sp_s6 + HALF_Z;

	always_ff @(posedge clk) begin
		if (en) begin
			cy_s5 <= yn[CS-1] ? -yx[CS-1] : yx[CS-1];
			sy_s5 <= yn[CS-1] ? -yy[CS-1] : yy[CS-1];
			cp_s5 <= pn[CS-1] ? -px[CS-1] : px[CS-1];
			sp_s5 <= pn[CS-1] ? -py[CS-1] : py[CS-1];
			mx_s6 <= cp_s5 * cy_s5;
			my_s6 <= cp_s5 * sy_s5;
			sp_s6 <= sp_s5;
			fx_s7 <= sat18(24'($signed(rx[PW-1:44])));
			fy_s7 <= sat18(24'($signed(ry[PW-1:44])));
			fz_s7 <= sat18(24'($signed(rz[XY_W-1:14])));
		end
	end

	logic               last_v;
	logic               out_take;
	logic               out_free;
	logic signed [17:0] nx, ny, nz;
	logic               noor;
	logic signed [17:0] dx_q, dy_q, dz_q, kx_q, ky_q, kz_q;
	logic               oor_q, koor_q;

	assign last_v = side_q[LAT-1].vld;
	assign noor = side_q[LAT-1].oor;
	assign nx = noor ? '0 : fx_s7;
	assign ny = noor ? '0 : fy_s7;
	assign nz = noor ? '0 : fz_s7;
	assign out_take = out_v_q && out_ready;
	assign out_free = !out_v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (out_take) begin
				skid_v_q <= 1'b0;
			end
		end else if (en && last_v) begin
			if (out_free) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (out_take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (out_take) begin
				dx_q <= kx_q;
				dy_q <= ky_q;
				dz_q <= kz_q;
				oor_q <= koor_q;
			end
		end else if (en && last_v) begin
			if (out_free) begin
				dx_q <= nx;
				dy_q <= ny;
				dz_q <= nz;
				oor_q <= noor;
			end else begin
				kx_q <= nx;
				ky_q <= ny;
				kz_q <= nz;
				koor_q <= noor;
			end
		end
	end

	assign out_valid = out_v_q;
	assign dir_x = dx_q;
	assign dir_y = dy_q;
	assign dir_z = dz_q;
	assign out_of_range = oor_q;

	`ASSERT_IMP(a_skid_needs_out, clk, arst_n, skid_v_q, out_v_q)
	`ASSERT_IMP(a_oor_zero, clk, arst_n, out_valid && out_of_range,
		dir_x == 18'sd0 && dir_y == 18'sd0 && dir_z == 18'sd0)
	`ASSERT_IMP(a_z_range, clk, arst_n, out_valid,
		dir_z <= 18'sd65536 && dir_z >= -18'sd65536)
	`ASSERT_NXT(a_skid_drains, clk, arst_n, skid_v_q && out_ready, !skid_v_q)
endmodule
`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 1ps
module testbench;
	import crdg_pkg::*;

	localparam int STAGES = 18;
	localparam int CBITS = 12;
	localparam int DRAIN_CYCLES = CBITS + STAGES + 20;
	localparam logic [2:0] REG_SPARE_6 = 3'd6;
	localparam logic [2:0] REG_SPARE_7 = 3'd7;

	typedef struct {
		logic signed [17:0] x;
		logic signed [17:0] y;
		logic signed [17:0] z;
		logic oor;
	} ray_t;

	typedef struct {
		int col;
		int row;
		bit known;
	} pixel_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [30:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [CBITS-1:0] column = '0;
	logic [CBITS-1:0] pixel_row = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [17:0] dir_x, dir_y, dir_z;
	logic out_of_range;

	logic [30:0] fov_h, fov_v, step_h, step_v;
	logic [12:0] width, height;
	ray_t pending_rays[$];
	bit failed = 1'b0;
	bit no_idle = 1'b0;
	int stall_left = 0;

	camera_ray_direction_generator #(.CORDIC_STAGES(STAGES), .COORD_BITS(CBITS)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .column(column), .pixel_row(pixel_row),
		.out_valid(out_valid), .out_ready(out_ready),
		.dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z), .out_of_range(out_of_range)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#20ms;
		$display("Test completed with failures");
		$finish;
	end

	function automatic int pick_gap();
		int g;
		g = 0;
		if (!no_idle) begin
			if ($urandom_range(0, 11) == 0) begin
				g = $urandom_range(6, 40);
			end else if ($urandom_range(0, 2) == 0) begin
				g = $urandom_range(1, 3);
			end
		end
		return g;
	endfunction

	function automatic void sin_cos(input longint a, output longint c, output longint s);
		longint r, x, y, z, dx, dy;
		bit flip;
		r = a % longint'(TWO_PI_Q);
		flip = 1'b0;
		if (r < 0) begin
			r += longint'(TWO_PI_Q);
		end
		if (r >= longint'(PI_Q)) begin
			r -= longint'(TWO_PI_Q);
		end
		if (r > longint'(HALF_PI_Q)) begin
			r -= longint'(PI_Q);
			flip = 1'b1;
		end else if (r < -longint'(HALF_PI_Q)) begin
			r += longint'(PI_Q);
			flip = 1'b1;
		end
		x = longint'(GAIN_Q30);
		y = 0;
		z = r;
		for (int i = 0; i < STAGES && i < 30; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= longint'(ATAN_TAB[i]);
			end else begin
				x += dx;
				y -= dy;
				z += longint'(ATAN_TAB[i]);
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic logic signed [17:0] clamp_q16(input longint v);
		if (v > 65536) begin
			v = 65536;
		end else if (v < -65536) begin
			v = -65536;
		end
		return v[17:0];
	endfunction

	function automatic ray_t trace_ray(input logic [CBITS-1:0] col, input logic [CBITS-1:0] row);
		ray_t r;
		longint yaw, pitch, cy, sy, cp, sp;
		r = '{x: '0, y: '0, z: '0, oor: 1'b1};
		if (col < width && row < height) begin
			yaw = longint'(col) * longint'(step_h) - longint'(fov_h >> 1);
			pitch = longint'(fov_v >> 1) - longint'(row) * longint'(step_v);
			sin_cos(yaw, cy, sy);
			sin_cos(pitch, cp, sp);
			r.x = clamp_q16((cp * cy + (64'sd1 <<< 43)) >>> 44);
			r.y = clamp_q16((cp * sy + (64'sd1 <<< 43)) >>> 44);
			r.z = clamp_q16((sp + 64'sd8192) >>> 14);
			r.oor = 1'b0;
		end
		return r;
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [30:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_FOV_H: fov_h = d;
			REG_FOV_V: fov_v = d;
			REG_STEP_H: step_h = d;
			REG_STEP_V: step_v = d;
			REG_WIDTH: width = d[12:0];
			REG_HEIGHT: height = d[12:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic setup(input logic [30:0] fh, input logic [30:0] fv, input logic [30:0] sh,
		input logic [30:0] sv, input logic [12:0] w, input logic [12:0] h);
		write_reg(REG_FOV_H, fh);
		write_reg(REG_FOV_V, fv);
		write_reg(REG_STEP_H, sh);
		write_reg(REG_STEP_V, sv);
		write_reg(REG_WIDTH, {18'd0, w});
		write_reg(REG_HEIGHT, {18'd0, h});
	endtask

	// Sends one pixel and records its expected ray once the word is taken.
	task automatic send_pixel(input logic [CBITS-1:0] col, input logic [CBITS-1:0] row,
		input bit known);
		int g;
		ray_t r;
		g = pick_gap();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		column <= col;
		pixel_row <= row;
		do @(posedge clk); while (!in_ready);
		if (known) begin
			r = '{x: '0, y: '0, z: '0, oor: 1'b1};
		end else begin
			r = trace_ray(col, row);
		end
		pending_rays.push_back(r);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_rays.size() > 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [CBITS-1:0] pick_coord(input logic [12:0] lim);
		logic [CBITS-1:0] v;
		if (lim > 0 && $urandom_range(0, 7) != 0) begin
			v = CBITS'($urandom_range(0, (lim > 4096 ? 4096 : lim) - 1));
		end else begin
			v = CBITS'($urandom);
		end
		return v;
	endfunction

	always @(posedge clk) begin
		ray_t e;
		if (out_valid && out_ready) begin
			if (pending_rays.size() == 0) begin
				$error("unexpected ray word");
				failed = 1'b1;
			end else begin
				e = pending_rays.pop_front();
				if (dir_x !== e.x) begin
					$error("dir_x expected %0d got %0d", e.x, dir_x);
					failed = 1'b1;
				end
				if (dir_y !== e.y) begin
					$error("dir_y expected %0d got %0d", e.y, dir_y);
					failed = 1'b1;
				end
				if (dir_z !== e.z) begin
					$error("dir_z expected %0d got %0d", e.z, dir_z);
					failed = 1'b1;
				end
				if (out_of_range !== e.oor) begin
					$error("out_of_range expected %0d got %0d", e.oor, out_of_range);
					failed = 1'b1;
				end
			end
		end
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else begin
			stall_left <= pick_gap();
			out_ready <= 1'b1;
		end
	end

	initial begin
		pixel_row_t directed[12];
		logic [30:0] fh, fv;
		logic [12:0] w, h;
		fov_h = 31'd281104971;
		fov_v = 31'd210828714;
		step_h = 31'd281105;
		step_v = 31'd263536;
		width = 13'd1000;
		height = 13'd800;
		directed = '{
			'{0, 0, 0}, '{999, 799, 0}, '{1000, 0, 1}, '{0, 800, 1},
			'{4095, 4095, 1}, '{500, 400, 0}, '{999, 0, 0}, '{0, 799, 0},
			'{1, 1, 0}, '{2048, 1, 1}, '{1, 2048, 1}, '{3000, 700, 1}
		};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		foreach (directed[i]) begin
			send_pixel(CBITS'(directed[i].col), CBITS'(directed[i].row), directed[i].known);
		end
		drain();

		for (int phase = 0; phase < 8; phase++) begin
			no_idle = (phase % 3 == 1);
			case (phase)
				0: setup(31'd1686629713, 31'd1686629713, 31'd1686629713, 31'd1686629713,
					13'd4096, 13'd4096);
				1: setup(31'd0, 31'd0, 31'd0, 31'd0, 13'd8191, 13'd8191);
				2: setup(31'd281104971, 31'd210828714, 31'd281105, 31'd263536, 13'd1, 13'd1);
				3: begin
					setup(31'd0, 31'd0, 31'd0, 31'd0, 13'd0, 13'd0);
					write_reg(REG_SPARE_6, 31'($urandom));
					write_reg(REG_SPARE_7, 31'($urandom));
				end
				4, 5: begin
					fh = 31'($urandom_range(0, 1686629713));
					fv = 31'($urandom_range(0, 1686629713));
					w = 13'($urandom_range(1, 4096));
					h = 13'($urandom_range(1, 4096));
					setup(fh, fv, fh / w, fv / h, w, h);
				end
				default: setup(31'($urandom), 31'($urandom), 31'($urandom), 31'($urandom),
					13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)));
			endcase
			for (int n = 0; n < 160; n++) begin
				send_pixel(pick_coord(width), pick_coord(height), 1'b0);
			end
			drain();
		end

		if (!failed) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/crdg_pkg.sv
hw/rtl/crdg_mod_cell.sv
hw/rtl/crdg_fold.sv
hw/rtl/crdg_cordic_cell.sv
hw/rtl/camera_ray_direction_generator.sv
dv/testbench.sv
